// ===== design/fpc_pkg.sv =====
// Shared constants and defaults for the finger pose classifier.
package fpc_pkg;

	// Default field widths
	localparam int COORD_WIDTH_DEF = 16;
	localparam int CONF_WIDTH_DEF  = 8;

	// Confidence minimums in percent
	localparam int EXT_TIP_PCT   = 45;
	localparam int EXT_PIP_PCT   = 40;
	localparam int EXT_DIP_PCT   = 40;
	localparam int EXT_BASE_PCT  = 35;
	localparam int FOLD_TIP_PCT  = 35;
	localparam int FOLD_PIP_PCT  = 30;
	localparam int FOLD_BASE_PCT = 30;

	// Squared cosine of 142 degrees, Q0.32, rounded to nearest
	localparam logic [31:0] K_COS2_142 = 32'd2667006963;

	// Squared distance ratios: 1.16^2 = 841/625, 1.18^2 = 3481/2500
	localparam int EXT_TM_MUL  = 625;
	localparam int EXT_PM_MUL  = 841;
	localparam int FOLD_TM_MUL = 2500;
	localparam int FOLD_PM_MUL = 3481;

	// Scales for the short-arm limit (0.001^2), the pip floor (0.01^2)
	// and the tip distance needed when the floor applies (1.16^2 * 0.01^2)
	localparam longint unsigned SHORT_SCALE    = 64'd1000000;
	localparam longint unsigned FLOOR_SCALE    = 64'd10000;
	localparam longint unsigned EXT_FLOOR_NUM  = 64'd13456;
	localparam longint unsigned EXT_FLOOR_DEN  = 64'd100000000;

endpackage

// ===== design/fpc_in_if.sv =====
// Landmark channel: four points with confidences, valid/ready handshake.
interface fpc_in_if
	import fpc_pkg::*;
#(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int CONF_WIDTH  = CONF_WIDTH_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] tip_x;
	logic signed [COORD_WIDTH-1:0] tip_y;
	logic        [CONF_WIDTH-1:0]  tip_conf;
	logic signed [COORD_WIDTH-1:0] pip_x;
	logic signed [COORD_WIDTH-1:0] pip_y;
	logic        [CONF_WIDTH-1:0]  pip_conf;
	logic signed [COORD_WIDTH-1:0] dip_x;
	logic signed [COORD_WIDTH-1:0] dip_y;
	logic        [CONF_WIDTH-1:0]  dip_conf;
	logic signed [COORD_WIDTH-1:0] base_x;
	logic signed [COORD_WIDTH-1:0] base_y;
	logic        [CONF_WIDTH-1:0]  base_conf;

	modport source (
		output valid, tip_x, tip_y, tip_conf, pip_x, pip_y, pip_conf,
		       dip_x, dip_y, dip_conf, base_x, base_y, base_conf,
		input  ready
	);
	modport sink (
		input  valid, tip_x, tip_y, tip_conf, pip_x, pip_y, pip_conf,
		       dip_x, dip_y, dip_conf, base_x, base_y, base_conf,
		output ready
	);
endinterface

// ===== design/fpc_out_if.sv =====
// Pose channel: extended and folded flags, valid/ready handshake.
interface fpc_out_if;
	logic valid;
	logic ready;
	logic is_extended;
	logic is_folded;

	modport source (output valid, is_extended, is_folded, input ready);
	modport sink (input valid, is_extended, is_folded, output ready);
endinterface

// ===== design/finger_pose_classifier_unit.sv =====
// Throughput: one word per cycle while the output is not stalled; every stage
// has its own valid bit and advances when it is empty or the stage after it
// advances, so bubbles close up under stall.
// Depth is set by the exact angle test: |dot|^2 and |a|^2*|b|^2 are built from
// half-width partial products, then the 142-degree cosine product is summed in two steps.
// Reset (arst_n low) clears all valid bits; the data registers are not reset.
module finger_pose_classifier_unit
	import fpc_pkg::*;
#(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int CONF_WIDTH  = CONF_WIDTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	fpc_in_if.sink    landmarks,
	fpc_out_if.source pose
);

	// Widths: differences, squares and sums of squares, dot product,
	// half words for the split multipliers, ratio products, cosine products.
	localparam int DW   = COORD_WIDTH + 1;
	localparam int N    = 2 * DW;
	localparam int H    = DW;
	localparam int DOTW = N + 1;
	localparam int RW   = N + 12;
	localparam int PKW  = H + 32;
	localparam int SW   = 2 * H + 33;
	localparam int TW   = 4 * H + 32;
	localparam int NSTG = 10;

	// Fixed-point unit squared and the thresholds that follow from it
	localparam int FRAC = COORD_WIDTH - 4;
	localparam longint unsigned UNIT_SQ   = 64'd1 << (2 * FRAC);
	localparam longint unsigned SHORT_LIM = (UNIT_SQ + SHORT_SCALE - 1) / SHORT_SCALE;
	localparam longint unsigned PM_FLOOR  = (UNIT_SQ + FLOOR_SCALE - 1) / FLOOR_SCALE;
	localparam longint unsigned TM_MIN    =
		(EXT_FLOOR_NUM * UNIT_SQ + EXT_FLOOR_DEN - 1) / EXT_FLOOR_DEN;

	// Confidence minimums as raw codes: conf * 100 >= pct * 2^CONF_WIDTH
	localparam int CONF_ONE      = 1 << CONF_WIDTH;
	localparam int EXT_TIP_MIN   = (EXT_TIP_PCT * CONF_ONE + 99) / 100;
	localparam int EXT_PIP_MIN   = (EXT_PIP_PCT * CONF_ONE + 99) / 100;
	localparam int EXT_DIP_MIN   = (EXT_DIP_PCT * CONF_ONE + 99) / 100;
	localparam int EXT_BASE_MIN  = (EXT_BASE_PCT * CONF_ONE + 99) / 100;
	localparam int FOLD_TIP_MIN  = (FOLD_TIP_PCT * CONF_ONE + 99) / 100;
	localparam int FOLD_PIP_MIN  = (FOLD_PIP_PCT * CONF_ONE + 99) / 100;
	localparam int FOLD_BASE_MIN = (FOLD_BASE_PCT * CONF_ONE + 99) / 100;

	// Decision bits gathered along the pipe; each is filled at the stage
	// where it becomes known and then rides along with the word.
	typedef struct packed {
		logic conf_ext;
		logic conf_fold;
		logic short_p;
		logic short_d;
		logic neg_p;
		logic neg_d;
		logic pm_big;
		logic tm_big;
		logic ext_rat;
		logic fold_rat;
		logic ge135;
		logic le150;
	} flag_t;

	// ---------------------------------------------------------------
	// Flow control: a stage loads when it is empty or its successor loads
	// ---------------------------------------------------------------
	logic [NSTG:1] vld_q;
	logic [NSTG:1] adv;

	always_comb begin
		adv[NSTG] = !vld_q[NSTG] || pose.ready;
		for (int k = NSTG - 1; k >= 1; k--) begin
			adv[k] = !vld_q[k] || adv[k + 1];
		end
	end

	assign landmarks.ready = adv[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[1]) begin
				vld_q[1] <= landmarks.valid;
			end
			for (int k = 2; k <= NSTG; k++) begin
				if (adv[k]) begin
					vld_q[k] <= vld_q[k - 1];
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Stage 1: arm vectors. Joint 0 is the pip joint (arms to base and tip),
	// joint 1 the dip joint (arms to pip and tip). The pip arm to the base
	// doubles as the pip-to-base distance of the ratio tests.
	// ---------------------------------------------------------------
	logic signed [DW-1:0] ax_s1 [2];
	logic signed [DW-1:0] ay_s1 [2];
	logic signed [DW-1:0] bx_s1 [2];
	logic signed [DW-1:0] by_s1 [2];
	logic signed [DW-1:0] tmx_s1;
	logic signed [DW-1:0] tmy_s1;
	flag_t                fl_s1;
	flag_t                fl1_c;

	always_comb begin
		fl1_c           = '0;
		fl1_c.conf_ext  = (landmarks.tip_conf >= CONF_WIDTH'(EXT_TIP_MIN))
			&& (landmarks.pip_conf >= CONF_WIDTH'(EXT_PIP_MIN))
			&& (landmarks.dip_conf >= CONF_WIDTH'(EXT_DIP_MIN))
			&& (landmarks.base_conf >= CONF_WIDTH'(EXT_BASE_MIN));
		fl1_c.conf_fold = (landmarks.tip_conf >= CONF_WIDTH'(FOLD_TIP_MIN))
			&& (landmarks.pip_conf >= CONF_WIDTH'(FOLD_PIP_MIN))
			&& (landmarks.base_conf >= CONF_WIDTH'(FOLD_BASE_MIN));
	end

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			ax_s1[0] <= DW'(landmarks.base_x) - DW'(landmarks.pip_x);
			ay_s1[0] <= DW'(landmarks.base_y) - DW'(landmarks.pip_y);
			bx_s1[0] <= DW'(landmarks.tip_x) - DW'(landmarks.pip_x);
			by_s1[0] <= DW'(landmarks.tip_y) - DW'(landmarks.pip_y);
			ax_s1[1] <= DW'(landmarks.pip_x) - DW'(landmarks.dip_x);
			ay_s1[1] <= DW'(landmarks.pip_y) - DW'(landmarks.dip_y);
			bx_s1[1] <= DW'(landmarks.tip_x) - DW'(landmarks.dip_x);
			by_s1[1] <= DW'(landmarks.tip_y) - DW'(landmarks.dip_y);
			tmx_s1   <= DW'(landmarks.tip_x) - DW'(landmarks.base_x);
			tmy_s1   <= DW'(landmarks.tip_y) - DW'(landmarks.base_y);
			fl_s1    <= fl1_c;
		end
	end

	// ---------------------------------------------------------------
	// Stage 2: squares and cross terms of every arm
	// ---------------------------------------------------------------
	logic signed [N-1:0] sqax_s2 [2];
	logic signed [N-1:0] sqay_s2 [2];
	logic signed [N-1:0] sqbx_s2 [2];
	logic signed [N-1:0] sqby_s2 [2];
	logic signed [N-1:0] prx_s2  [2];
	logic signed [N-1:0] pry_s2  [2];
	logic signed [N-1:0] sqtx_s2;
	logic signed [N-1:0] sqty_s2;
	flag_t               fl_s2;

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			for (int j = 0; j < 2; j++) begin
				sqax_s2[j] <= ax_s1[j] * ax_s1[j];
				sqay_s2[j] <= ay_s1[j] * ay_s1[j];
				sqbx_s2[j] <= bx_s1[j] * bx_s1[j];
				sqby_s2[j] <= by_s1[j] * by_s1[j];
				prx_s2[j]  <= ax_s1[j] * bx_s1[j];
				pry_s2[j]  <= ay_s1[j] * by_s1[j];
			end
			sqtx_s2 <= tmx_s1 * tmx_s1;
			sqty_s2 <= tmy_s1 * tmy_s1;
			fl_s2   <= fl_s1;
		end
	end

	// ---------------------------------------------------------------
	// Stage 3: squared arm lengths and dot products
	// ---------------------------------------------------------------
	logic        [N-1:0]    la2_s3 [2];
	logic        [N-1:0]    lb2_s3 [2];
	logic signed [DOTW-1:0] dot_s3 [2];
	logic        [N-1:0]    tm2_s3;
	flag_t                  fl_s3;

	always_ff @(posedge clk) begin
		if (adv[3]) begin
			for (int j = 0; j < 2; j++) begin
				la2_s3[j] <= $unsigned(sqax_s2[j]) + $unsigned(sqay_s2[j]);
				lb2_s3[j] <= $unsigned(sqbx_s2[j]) + $unsigned(sqby_s2[j]);
				dot_s3[j] <= DOTW'(prx_s2[j]) + DOTW'(pry_s2[j]);
			end
			tm2_s3 <= $unsigned(sqtx_s2) + $unsigned(sqty_s2);
			fl_s3  <= fl_s2;
		end
	end

	// ---------------------------------------------------------------
	// Stage 4: dot magnitude, short-arm, sign and floor flags, ratio products
	// ---------------------------------------------------------------
	logic signed [DOTW-1:0] dot_neg [2];
	logic        [N-1:0]    mag_c   [2];
	flag_t                  fl4_c;

	always_comb begin
		for (int j = 0; j < 2; j++) begin
			dot_neg[j] = -dot_s3[j];
			mag_c[j]   = dot_s3[j][DOTW-1] ? dot_neg[j][N-1:0] : dot_s3[j][N-1:0];
		end
	end

	always_comb begin
		fl4_c         = fl_s3;
		fl4_c.short_p = (la2_s3[0] < N'(SHORT_LIM)) || (lb2_s3[0] < N'(SHORT_LIM));
		fl4_c.short_d = (la2_s3[1] < N'(SHORT_LIM)) || (lb2_s3[1] < N'(SHORT_LIM));
		fl4_c.neg_p   = dot_s3[0][DOTW-1];
		fl4_c.neg_d   = dot_s3[1][DOTW-1];
		fl4_c.pm_big  = la2_s3[0] >= N'(PM_FLOOR);
		fl4_c.tm_big  = tm2_s3 >= N'(TM_MIN);
	end

	logic [N-1:0]  mag_s4 [2];
	logic [N-1:0]  la2_s4 [2];
	logic [N-1:0]  lb2_s4 [2];
	logic [RW-1:0] tmext_s4;
	logic [RW-1:0] pmext_s4;
	logic [RW-1:0] tmfold_s4;
	logic [RW-1:0] pmfold_s4;
	flag_t         fl_s4;

	always_ff @(posedge clk) begin
		if (adv[4]) begin
			for (int j = 0; j < 2; j++) begin
				mag_s4[j] <= mag_c[j];
				la2_s4[j] <= la2_s3[j];
				lb2_s4[j] <= lb2_s3[j];
			end
			tmext_s4  <= RW'(tm2_s3) * RW'(EXT_TM_MUL);
			pmext_s4  <= RW'(la2_s3[0]) * RW'(EXT_PM_MUL);
			tmfold_s4 <= RW'(tm2_s3) * RW'(FOLD_TM_MUL);
			pmfold_s4 <= RW'(la2_s3[0]) * RW'(FOLD_PM_MUL);
			fl_s4     <= fl4_c;
		end
	end

	// ---------------------------------------------------------------
	// Stage 5: half-word partial products of |dot|^2 and |a|^2*|b|^2;
	// resolve both distance ratios (floored divisor for extension)
	// ---------------------------------------------------------------
	logic [2*H-1:0] mll_s5 [2];
	logic [2*H-1:0] mlh_s5 [2];
	logic [2*H-1:0] mhh_s5 [2];
	logic [2*H-1:0] pll_s5 [2];
	logic [2*H-1:0] plh_s5 [2];
	logic [2*H-1:0] phl_s5 [2];
	logic [2*H-1:0] phh_s5 [2];
	flag_t          fl_s5;
	flag_t          fl5_c;

	always_comb begin
		fl5_c          = fl_s4;
		fl5_c.ext_rat  = fl_s4.pm_big ? (tmext_s4 >= pmext_s4) : fl_s4.tm_big;
		fl5_c.fold_rat = tmfold_s4 <= pmfold_s4;
	end

	always_ff @(posedge clk) begin
		if (adv[5]) begin
			for (int j = 0; j < 2; j++) begin
				mll_s5[j] <= (2*H)'(mag_s4[j][H-1:0]) * (2*H)'(mag_s4[j][H-1:0]);
				mlh_s5[j] <= (2*H)'(mag_s4[j][H-1:0]) * (2*H)'(mag_s4[j][N-1:H]);
				mhh_s5[j] <= (2*H)'(mag_s4[j][N-1:H]) * (2*H)'(mag_s4[j][N-1:H]);
				pll_s5[j] <= (2*H)'(la2_s4[j][H-1:0]) * (2*H)'(lb2_s4[j][H-1:0]);
				plh_s5[j] <= (2*H)'(la2_s4[j][H-1:0]) * (2*H)'(lb2_s4[j][N-1:H]);
				phl_s5[j] <= (2*H)'(la2_s4[j][N-1:H]) * (2*H)'(lb2_s4[j][H-1:0]);
				phh_s5[j] <= (2*H)'(la2_s4[j][N-1:H]) * (2*H)'(lb2_s4[j][N-1:H]);
			end
			fl_s5 <= fl5_c;
		end
	end

	// ---------------------------------------------------------------
	// Stage 6: |dot|^2 complete; middle terms of the length product summed
	// ---------------------------------------------------------------
	logic [4*H-1:0] msq_s6 [2];
	logic [2*H-1:0] pll_s6 [2];
	logic [2*H-1:0] phh_s6 [2];
	logic [2*H:0]   pmid_s6 [2];
	flag_t          fl_s6;

	always_ff @(posedge clk) begin
		if (adv[6]) begin
			for (int j = 0; j < 2; j++) begin
				msq_s6[j]  <= {mhh_s5[j], mll_s5[j]} + ((4*H)'({mlh_s5[j], 1'b0}) << H);
				pll_s6[j]  <= pll_s5[j];
				phh_s6[j]  <= phh_s5[j];
				pmid_s6[j] <= (2*H+1)'(plh_s5[j]) + (2*H+1)'(phl_s5[j]);
			end
			fl_s6 <= fl_s5;
		end
	end

	// ---------------------------------------------------------------
	// Stage 7: |a|^2*|b|^2 complete
	// ---------------------------------------------------------------
	logic [4*H-1:0] msq_s7  [2];
	logic [4*H-1:0] prod_s7 [2];
	flag_t          fl_s7;

	always_ff @(posedge clk) begin
		if (adv[7]) begin
			for (int j = 0; j < 2; j++) begin
				msq_s7[j]  <= msq_s6[j];
				prod_s7[j] <= {phh_s6[j], pll_s6[j]} + ((4*H)'(pmid_s6[j]) << H);
			end
			fl_s7 <= fl_s6;
		end
	end

	// ---------------------------------------------------------------
	// Stage 8: dip joint at 135 degrees (cos^2 = 1/2) and pip joint at
	// 150 degrees (cos^2 = 3/4) by shifts; cos^2(142) times the pip
	// length product split into four half-word chunks
	// ---------------------------------------------------------------
	logic [4*H-1:0] msq_s8;
	logic [PKW-1:0] pk_s8 [4];
	flag_t          fl_s8;
	flag_t          fl8_c;

	always_comb begin
		fl8_c       = fl_s7;
		fl8_c.ge135 = {msq_s7[1], 1'b0} >= (4*H+1)'(prod_s7[1]);
		fl8_c.le150 = {msq_s7[0], 2'b00}
			<= (4*H+2)'(prod_s7[0]) + (4*H+2)'({prod_s7[0], 1'b0});
	end

	always_ff @(posedge clk) begin
		if (adv[8]) begin
			msq_s8 <= msq_s7[0];
			for (int i = 0; i < 4; i++) begin
				pk_s8[i] <= PKW'(prod_s7[0][i*H +: H]) * PKW'(K_COS2_142);
			end
			fl_s8 <= fl8_c;
		end
	end

	// ---------------------------------------------------------------
	// Stage 9: pairwise sums of the cosine chunks
	// ---------------------------------------------------------------
	logic [4*H-1:0] msq_s9;
	logic [SW-1:0]  klo_s9;
	logic [SW-1:0]  khi_s9;
	flag_t          fl_s9;

	always_ff @(posedge clk) begin
		if (adv[9]) begin
			msq_s9 <= msq_s8;
			klo_s9 <= SW'(pk_s8[0]) + (SW'(pk_s8[1]) << H);
			khi_s9 <= SW'(pk_s8[2]) + (SW'(pk_s8[3]) << H);
			fl_s9  <= fl_s8;
		end
	end

	// ---------------------------------------------------------------
	// Stage 10 (output register): pip joint at 142 degrees, then both flags.
	// An obtuse-angle test holds only for a negative dot product and no
	// short arm; the folded angle test passes for any short arm.
	// ---------------------------------------------------------------
	logic [TW-1:0] kprod;
	logic          ge142;
	logic          ext_c;
	logic          fold_c;

	always_comb begin
		kprod  = TW'(klo_s9) + (TW'(khi_s9) << (2 * H));
		ge142  = {msq_s9, 32'd0} >= kprod;
		ext_c  = fl_s9.conf_ext && !fl_s9.short_p && fl_s9.neg_p && ge142
			&& !fl_s9.short_d && fl_s9.neg_d && fl_s9.ge135 && fl_s9.ext_rat;
		fold_c = fl_s9.conf_fold && (fl_s9.short_p || !fl_s9.neg_p || fl_s9.le150
			|| fl_s9.fold_rat);
	end

	logic ext_s10;
	logic fold_s10;

	always_ff @(posedge clk) begin
		if (adv[10]) begin
			ext_s10  <= ext_c;
			fold_s10 <= fold_c;
		end
	end

	assign pose.valid       = vld_q[NSTG];
	assign pose.is_extended = ext_s10;
	assign pose.is_folded   = fold_s10;

	// ---------------------------------------------------------------
	// Checks
	// ---------------------------------------------------------------
	// An empty first stage always takes a word.
	assert property (@(posedge clk) disable iff (!arst_n)
		!vld_q[1] |-> landmarks.ready)
		else $error("entry stage empty but landmark channel not ready");

	// A full pipe behind a stalled output refuses new words.
	assert property (@(posedge clk) disable iff (!arst_n)
		(&vld_q && !pose.ready) |-> !landmarks.ready)
		else $error("word accepted into a full stalled pipe");

	// The stage before a stalled output keeps its word.
	assert property (@(posedge clk) disable iff (!arst_n)
		(pose.valid && !pose.ready && vld_q[NSTG-1]) |=> vld_q[NSTG-1])
		else $error("word dropped behind a stalled output");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// Testbench for the finger pose classifier: scoreboard, stimulus and checks.
import fpc_pkg::*;

// One landmark word as it crosses the input channel
typedef struct {
	logic signed [COORD_WIDTH_DEF-1:0] tip_x;
	logic signed [COORD_WIDTH_DEF-1:0] tip_y;
	logic        [CONF_WIDTH_DEF-1:0]  tip_conf;
	logic signed [COORD_WIDTH_DEF-1:0] pip_x;
	logic signed [COORD_WIDTH_DEF-1:0] pip_y;
	logic        [CONF_WIDTH_DEF-1:0]  pip_conf;
	logic signed [COORD_WIDTH_DEF-1:0] dip_x;
	logic signed [COORD_WIDTH_DEF-1:0] dip_y;
	logic        [CONF_WIDTH_DEF-1:0]  dip_conf;
	logic signed [COORD_WIDTH_DEF-1:0] base_x;
	logic signed [COORD_WIDTH_DEF-1:0] base_y;
	logic        [CONF_WIDTH_DEF-1:0]  base_conf;
} landmark_t;

// One pose word as it leaves the output channel
typedef struct {
	logic is_extended;
	logic is_folded;
} pose_t;

// Arm lengths and dot product seen at one joint
typedef struct {
	bit                  short_arm;
	longint              dot;
	longint unsigned     la2;
	longint unsigned     lb2;
} joint_t;

class pose_scoreboard;
	localparam longint unsigned UNIT_SQ     = 64'd1 << (2 * (COORD_WIDTH_DEF - 4));
	localparam longint unsigned SHORT_LIMIT = (UNIT_SQ + SHORT_SCALE - 1) / SHORT_SCALE;
	localparam longint unsigned COS2_135    = 64'd1 << 31;
	localparam longint unsigned COS2_150    = 64'd3 << 30;

	pose_t expected_q[$];
	int    mismatches;
	int    checked;
	int    extended_seen;
	int    folded_seen;

	function new();
		mismatches = 0;
		checked = 0;
		extended_seen = 0;
		folded_seen = 0;
	endfunction

	function int pending();
		return expected_q.size();
	endfunction

	task report_mismatch(string what);
		$display("[%0t] mismatch: %s", $realtime, what);
		mismatches++;
	endtask

	function bit conf_met(logic [CONF_WIDTH_DEF-1:0] c, int pct);
		return (longint'(c) * 100) >= (longint'(pct) << CONF_WIDTH_DEF);
	endfunction

	function joint_t measure_joint(longint fx, longint fy, longint jx, longint jy,
			longint lx, longint ly);
		joint_t j;
		longint ax, ay, bx, by;
		ax = fx - jx;
		ay = fy - jy;
		bx = lx - jx;
		by = ly - jy;
		j.la2 = ax * ax + ay * ay;
		j.lb2 = bx * bx + by * by;
		j.dot = ax * bx + ay * by;
		j.short_arm = (j.la2 < SHORT_LIMIT) || (j.lb2 < SHORT_LIMIT);
		return j;
	endfunction

	// Sign of dot^2 * 2^32 - k * |a|^2 * |b|^2, exact in 128 bits
	function int cos_cmp(joint_t j, longint unsigned k);
		logic [127:0]    lhs, rhs;
		longint unsigned m;
		m = (j.dot < 0) ? longint'(-j.dot) : j.dot;
		lhs = 128'(m) * 128'(m);
		lhs = lhs << 32;
		rhs = 128'(k) * 128'(j.la2) * 128'(j.lb2);
		if (lhs > rhs)
			return 1;
		if (lhs < rhs)
			return -1;
		return 0;
	endfunction

	function bit wider_than(joint_t j, longint unsigned k);
		if (j.short_arm || j.dot >= 0)
			return 1'b0;
		return cos_cmp(j, k) >= 0;
	endfunction

	function bit narrower_than(joint_t j, longint unsigned k);
		if (j.short_arm || j.dot >= 0)
			return 1'b1;
		return cos_cmp(j, k) <= 0;
	endfunction

	function pose_t classify(landmark_t w);
		pose_t           p;
		joint_t          pj, dj;
		longint          tx, ty, px, py, dx, dy, bx, by;
		longint unsigned tm2, pm2;
		bit              long_enough;
		tx = w.tip_x;  ty = w.tip_y;
		px = w.pip_x;  py = w.pip_y;
		dx = w.dip_x;  dy = w.dip_y;
		bx = w.base_x; by = w.base_y;
		pj = measure_joint(bx, by, px, py, tx, ty);
		dj = measure_joint(px, py, dx, dy, tx, ty);
		tm2 = (tx - bx) * (tx - bx) + (ty - by) * (ty - by);
		pm2 = (px - bx) * (px - bx) + (py - by) * (py - by);
		p.is_extended = 1'b0;
		p.is_folded = 1'b0;
		if (conf_met(w.tip_conf, EXT_TIP_PCT) && conf_met(w.pip_conf, EXT_PIP_PCT) &&
				conf_met(w.dip_conf, EXT_DIP_PCT) && conf_met(w.base_conf, EXT_BASE_PCT)) begin
			// floor the pip-to-base distance at 0.01
			if (pm2 * FLOOR_SCALE >= UNIT_SQ)
				long_enough = tm2 * EXT_TM_MUL >= pm2 * EXT_PM_MUL;
			else
				long_enough = tm2 * EXT_FLOOR_DEN >= EXT_FLOOR_NUM * UNIT_SQ;
			p.is_extended = wider_than(pj, 64'(K_COS2_142)) && wider_than(dj, COS2_135) &&
				long_enough;
		end
		if (conf_met(w.tip_conf, FOLD_TIP_PCT) && conf_met(w.pip_conf, FOLD_PIP_PCT) &&
				conf_met(w.base_conf, FOLD_BASE_PCT))
			p.is_folded = narrower_than(pj, COS2_150) || (tm2 * FOLD_TM_MUL <= pm2 * FOLD_PM_MUL);
		return p;
	endfunction

	function void note_landmarks(landmark_t w);
		expected_q.push_back(classify(w));
	endfunction

	task check_pose(pose_t got);
		pose_t want;
		if (expected_q.size() == 0) begin
			report_mismatch("pose word with no landmark word outstanding");
			return;
		end
		want = expected_q.pop_front();
		checked++;
		if (got.is_extended === 1'b1)
			extended_seen++;
		if (got.is_folded === 1'b1)
			folded_seen++;
		if (got.is_extended !== want.is_extended)
			report_mismatch($sformatf("word %0d is_extended %b, want %b",
				checked, got.is_extended, want.is_extended));
		if (got.is_folded !== want.is_folded)
			report_mismatch($sformatf("word %0d is_folded %b, want %b",
				checked, got.is_folded, want.is_folded));
	endtask
endclass

module testbench;
	localparam int RANDOM_ITEMS = 1730;
	localparam int DRAIN_CYCLES = 30;

	logic clk;
	logic arst_n;
	bit   steady;

	fpc_in_if  lm();
	fpc_out_if pose();

	pose_scoreboard sb = new();

	finger_pose_classifier_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.landmarks(lm),
		.pose     (pose)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Hard stop in case a handshake never completes
	initial begin
		#10_000_000;
		$display("run exceeded its time limit");
		$display("FAILURE");
		$finish;
	end

	function automatic int jitter(int r);
		return int'($urandom_range(0, 2 * r)) - r;
	endfunction

	function automatic landmark_t make_landmarks(int tx, int ty, int tc, int px, int py, int pc,
			int dx, int dy, int dc, int bx, int by, int bc);
		landmark_t w;
		w.tip_x = COORD_WIDTH_DEF'(tx);  w.tip_y = COORD_WIDTH_DEF'(ty);
		w.tip_conf = CONF_WIDTH_DEF'(tc);
		w.pip_x = COORD_WIDTH_DEF'(px);  w.pip_y = COORD_WIDTH_DEF'(py);
		w.pip_conf = CONF_WIDTH_DEF'(pc);
		w.dip_x = COORD_WIDTH_DEF'(dx);  w.dip_y = COORD_WIDTH_DEF'(dy);
		w.dip_conf = CONF_WIDTH_DEF'(dc);
		w.base_x = COORD_WIDTH_DEF'(bx); w.base_y = COORD_WIDTH_DEF'(by);
		w.base_conf = CONF_WIDTH_DEF'(bc);
		return w;
	endfunction

	// Confidence: mostly solid, often right at a gate, sometimes anything
	function automatic int conf_pick();
		int gate_vals[8] = '{76, 77, 89, 90, 102, 103, 115, 116};
		case ($urandom_range(0, 9))
			0, 1: return gate_vals[$urandom_range(0, 7)];
			2: return $urandom_range(0, 255);
			default: return $urandom_range(200, 255);
		endcase
	endfunction

	function automatic landmark_t random_landmarks();
		int bx, by, ux, uy, jr, px, py, dx, dy, tx, ty;
		bx = jitter(12000);
		by = jitter(12000);
		ux = jitter(3000);
		uy = jitter(3000);
		case ($urandom_range(0, 4))
			0: jr = 0;
			1: jr = 60;
			2: jr = 400;
			3: jr = 1200;
			default: jr = 2500;
		endcase
		case ($urandom_range(0, 9))
			0, 1: begin
				// raw noise across every bit
				return make_landmarks($urandom, $urandom, $urandom, $urandom, $urandom,
					$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
			end
			2, 3, 4, 5: begin
				// near-straight finger, jitter sweeps the angles across the gates
				px = bx + ux + jitter(jr);
				py = by + uy + jitter(jr);
				dx = px + ux * 3 / 4 + jitter(jr);
				dy = py + uy * 3 / 4 + jitter(jr);
				tx = dx + ux * 3 / 4 + jitter(jr);
				ty = dy + uy * 3 / 4 + jitter(jr);
			end
			6, 7: begin
				// curled finger: dip turns aside, tip comes back toward the base
				px = bx + ux;
				py = by + uy;
				dx = px - uy / 2 + jitter(jr);
				dy = py + ux / 2 + jitter(jr);
				tx = dx - ux / 2 + jitter(jr);
				ty = dy - uy / 2 + jitter(jr);
			end
			8: begin
				// near-coincident points: short arms
				px = bx + jitter(20);
				py = by + jitter(20);
				dx = px + jitter(5);
				dy = py + jitter(5);
				if ($urandom_range(0, 1)) begin
					tx = dx + jitter(5);
					ty = dy + jitter(5);
				end else begin
					tx = bx + jitter(3000);
					ty = by + jitter(3000);
				end
			end
			default: begin
				// pip near base, around the 0.01 floor of the ratio
				px = bx + jitter(60);
				py = by + jitter(60);
				dx = px + (px - bx);
				dy = py + (py - by);
				tx = bx + jitter(150);
				ty = by + jitter(150);
			end
		endcase
		return make_landmarks(tx, ty, conf_pick(), px, py, conf_pick(), dx, dy, conf_pick(),
			bx, by, conf_pick());
	endfunction

	// Present one landmark word, hold it until the block takes it
	task automatic send_landmarks(landmark_t w);
		if (!steady && $urandom_range(0, 3) == 0) begin
			lm.valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		lm.valid     <= 1'b1;
		lm.tip_x     <= w.tip_x;
		lm.tip_y     <= w.tip_y;
		lm.tip_conf  <= w.tip_conf;
		lm.pip_x     <= w.pip_x;
		lm.pip_y     <= w.pip_y;
		lm.pip_conf  <= w.pip_conf;
		lm.dip_x     <= w.dip_x;
		lm.dip_y     <= w.dip_y;
		lm.dip_conf  <= w.dip_conf;
		lm.base_x    <= w.base_x;
		lm.base_y    <= w.base_y;
		lm.base_conf <= w.base_conf;
		@(posedge clk);
		while (!lm.ready)
			@(posedge clk);
	endtask

	// Output backpressure: random stall bursts between runs of ready
	initial begin
		pose.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (!steady && $urandom_range(0, 3) == 0) begin
				pose.ready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end else begin
				pose.ready <= 1'b1;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end
		end
	end

	// Watch both channels at the edge; note the input word before checking the output
	always @(posedge clk) begin : watch_channels
		landmark_t seen;
		pose_t     got;
		if (arst_n === 1'b1) begin
			if (lm.valid && lm.ready) begin
				seen.tip_x     = lm.tip_x;
				seen.tip_y     = lm.tip_y;
				seen.tip_conf  = lm.tip_conf;
				seen.pip_x     = lm.pip_x;
				seen.pip_y     = lm.pip_y;
				seen.pip_conf  = lm.pip_conf;
				seen.dip_x     = lm.dip_x;
				seen.dip_y     = lm.dip_y;
				seen.dip_conf  = lm.dip_conf;
				seen.base_x    = lm.base_x;
				seen.base_y    = lm.base_y;
				seen.base_conf = lm.base_conf;
				sb.note_landmarks(seen);
			end
			if (pose.valid === 1'b1 && pose.ready) begin
				got.is_extended = pose.is_extended;
				got.is_folded = pose.is_folded;
				sb.check_pose(got);
			end
		end
	end

	initial begin
		steady = 1'b0;
		arst_n <= 1'b0;
		lm.valid     <= 1'b0;
		lm.tip_x     <= '0;
		lm.tip_y     <= '0;
		lm.tip_conf  <= '0;
		lm.pip_x     <= '0;
		lm.pip_y     <= '0;
		lm.pip_conf  <= '0;
		lm.dip_x     <= '0;
		lm.dip_y     <= '0;
		lm.dip_conf  <= '0;
		lm.base_x    <= '0;
		lm.base_y    <= '0;
		lm.base_conf <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// All points coincident, full and empty confidence
		send_landmarks(make_landmarks(0, 0, 255, 0, 0, 255, 0, 0, 255, 0, 0, 255));
		send_landmarks(make_landmarks(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		// Coordinate extremes
		send_landmarks(make_landmarks(-32768, -32768, 255, -32768, -32768, 255,
			-32768, -32768, 255, -32768, -32768, 255));
		send_landmarks(make_landmarks(32767, 32767, 255, 32767, 32767, 255,
			32767, 32767, 255, 32767, 32767, 255));
		// Full-span straight fingers along both diagonals
		send_landmarks(make_landmarks(32767, 32767, 255, -16384, -16384, 255,
			8192, 8192, 255, -32768, -32768, 255));
		send_landmarks(make_landmarks(-32768, 32767, 255, 16384, -16384, 255,
			-8192, 8192, 255, 32767, -32768, 255));
		// Straight finger, clean, then each extension gate just missed and just met
		send_landmarks(make_landmarks(0, 10000, 255, 0, 4000, 255, 0, 7000, 255, 0, 0, 255));
		send_landmarks(make_landmarks(0, 10000, 115, 0, 4000, 255, 0, 7000, 255, 0, 0, 255));
		send_landmarks(make_landmarks(0, 10000, 116, 0, 4000, 255, 0, 7000, 255, 0, 0, 255));
		send_landmarks(make_landmarks(0, 10000, 255, 0, 4000, 102, 0, 7000, 255, 0, 0, 255));
		send_landmarks(make_landmarks(0, 10000, 255, 0, 4000, 103, 0, 7000, 102, 0, 0, 255));
		send_landmarks(make_landmarks(0, 10000, 255, 0, 4000, 255, 0, 7000, 103, 0, 0, 89));
		send_landmarks(make_landmarks(0, 10000, 255, 0, 4000, 255, 0, 7000, 255, 0, 0, 90));
		// Curled finger, then each fold gate just missed and just met
		send_landmarks(make_landmarks(1500, 2000, 255, 0, 4000, 255, 1500, 5000, 255, 0, 0, 255));
		send_landmarks(make_landmarks(1500, 2000, 89, 0, 4000, 255, 1500, 5000, 0, 0, 0, 255));
		send_landmarks(make_landmarks(1500, 2000, 90, 0, 4000, 76, 1500, 5000, 0, 0, 0, 255));
		send_landmarks(make_landmarks(1500, 2000, 90, 0, 4000, 77, 1500, 5000, 0, 0, 0, 76));
		send_landmarks(make_landmarks(1500, 2000, 90, 0, 4000, 77, 1500, 5000, 0, 0, 0, 77));
		// Short arm at the pip: base sits one step off the pip
		send_landmarks(make_landmarks(0, 9000, 255, 1, 1, 255, 0, 5000, 255, 0, 0, 255));
		// Short arm at the dip: dip on top of the tip
		send_landmarks(make_landmarks(0, 9000, 255, 0, 4000, 255, 2, 8999, 255, 0, 0, 255));
		// Pip inside the 0.01 floor, tip just past and just short of the floored reach
		send_landmarks(make_landmarks(0, 48, 255, 0, 20, 255, 0, 34, 255, 0, 0, 255));
		send_landmarks(make_landmarks(0, 47, 255, 0, 20, 255, 0, 34, 255, 0, 0, 255));
		// Ratio near 1.18 with a wide pip angle
		send_landmarks(make_landmarks(0, 4720, 255, 0, 4000, 255, 0, 4400, 255, 0, 0, 255));
		send_landmarks(make_landmarks(0, 4721, 255, 0, 4000, 255, 0, 4400, 255, 0, 0, 255));

		// Random part: idle-heavy stretches, a quiet stretch every so often, quiet tail
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			steady = (i % 400 >= 300) || (i >= RANDOM_ITEMS - 200);
			send_landmarks(random_landmarks());
		end
		lm.valid <= 1'b0;

		// Drain the pipeline, then keep clocking a while for anything stray
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("checked %0d pose words: %0d extended, %0d folded, %0d mismatches",
			sb.checked, sb.extended_seen, sb.folded_seen, sb.mismatches);
		$display("stimulus: coordinate extremes, confidence gates, short arms, floored pip,");
		$display("straight, curled and near-coincident fingers under random stalls");
		if (sb.mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule
